@@ rtl/kfvi_pkg.sv @@
// Shared types and constants of the keyframe vector interpolator.
`default_nettype none

package kfvi_pkg;

  localparam int unsigned KEY_IDX_W   = 6;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned MaxKeysDef  = 64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Component 0 is x, 1 is y and 2 is z.
  typedef logic [2:0][VAL_W-1:0] vec3_t;

endpackage

`default_nettype wire

@@ rtl/kfvi_div.sv @@
// Restoring divider that yields the 16-bit interpolation factor, one bit a cycle.
`default_nettype none

module kfvi_div import kfvi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(FRAC_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] den_q;
  logic [FRAC_W-1:0] quot_q;

  logic [TIME_W:0]   shifted;
  logic              ge;
  logic [TIME_W-1:0] rem_d;

  // The remainder stays below the divisor, so the shifted value fits 33 bits.
  always_comb begin
    shifted = {rem_q, 1'b0};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? TIME_W'(shifted - {1'b0, den_q}) : shifted[TIME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FRAC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ rtl/keyframe_vec3_interpolator.sv @@
// Top level of the keyframe interpolator: key memories, search, division and mixing.
//
// The input channel carries load and query words. A load writes one key (time
// and x, y, z) into the key memories and is done in the cycle it is accepted;
// it produces no result. A query gives a sample time and produces one result
// word with the interpolated vector and a clamped flag.
// The configuration channel writes the number of keys in use; it is always
// ready, and the user must write it only while the block is idle; the block
// itself does not enforce this. A query walks the key-time memory one key per
// cycle until it finds the first key whose successor is later than the sample
// time. For a found key the query then reads the lower key, runs the bit-serial
// divider and the shared multiplier, and writes the result back into the output
// register; the write-back waits while the receiver stalls an earlier result.
// A single key, or a time at or past the last key, returns that key without
// division; a time before the lower key returns the lower key.
// One query is in flight at a time; the next word is accepted once the result
// has moved into the output register, even while the receiver stalls it.
// Reset sets the key count to one and empties the output register; the key
// memories are not cleared and must be loaded before they are queried.
`default_nettype none

module keyframe_vec3_interpolator import kfvi_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [KEY_IDX_W-1:0]    key_index_i,
  input  logic [TIME_W-1:0]       key_time_i,
  input  logic signed [VAL_W-1:0] key_x_i,
  input  logic signed [VAL_W-1:0] key_y_i,
  input  logic signed [VAL_W-1:0] key_z_i,
  input  logic [TIME_W-1:0]       sample_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] out_x_o,
  output logic signed [VAL_W-1:0] out_y_o,
  output logic signed [VAL_W-1:0] out_z_o,
  output logic                    clamped_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CNT_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW = AW + 1;
  localparam int unsigned PW = VAL_W + FRAC_W + 2;
  localparam logic [2:0]  MixLast = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_LO,
    ST_DIV,
    ST_MIX,
    ST_KEY,
    ST_WB
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [CNT_W-1:0]    key_count_q;
  logic [AW-1:0]       rd_idx_q;
  logic [2:0]          mc_q;

  logic [TIME_W-1:0]   time_mem [MAX_KEYS];
  vec3_t               vec_mem  [MAX_KEYS];
  logic [TIME_W-1:0]   time_rdata_q;
  vec3_t               vec_rdata_q;

  logic [TIME_W-1:0]   t_q;
  logic [TIME_W-1:0]   t_hi_q;
  logic                clamp_q;
  vec3_t               a_q;
  vec3_t               b_q;
  vec3_t               res_q;
  logic [FRAC_W-1:0]   f_q;
  logic signed [VAL_W:0]  diff_q;
  logic signed [PW-1:0]   prod_q;
  logic [VAL_W-1:0]    out_x_q;
  logic [VAL_W-1:0]    out_y_q;
  logic [VAL_W-1:0]    out_z_q;
  logic                out_clamped_q;

  logic [NW-1:0]       n_eff;
  logic [AW-1:0]       last_idx;
  logic                in_fire;
  logic                query_fire;
  logic                ld_we;
  logic                t_lt;
  logic                wb_fire;
  logic                time_re;
  logic [AW-1:0]       time_raddr;
  logic                vec_re;
  logic [AW-1:0]       vec_raddr;
  logic                div_start;
  logic                div_done;
  logic [FRAC_W-1:0]   div_quot;
  logic [1:0]          csel;
  logic [1:0]          rsel;
  logic signed [VAL_W:0]  diff_d;
  logic signed [PW-1:0]   prod_d;

  always_comb begin
    if (key_count_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(key_count_q);
    end
    last_idx = AW'(n_eff - NW'(1));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign query_fire  = in_fire && (opcode_i == OP_QUERY);
  assign ld_we       = in_fire && (opcode_i == OP_LOAD) &&
                       (32'(key_index_i) < 32'(MAX_KEYS));
  assign t_lt        = t_q < time_rdata_q;
  assign wb_fire     = (state_q == ST_WB) && (!out_valid_q || out_ready_i);

  // In the search state the time register holds the successor key's time; in the
  // lower-key state the same register holds the lower key's time.
  always_comb begin
    time_re    = 1'b0;
    time_raddr = rd_idx_q;
    vec_re     = 1'b0;
    vec_raddr  = rd_idx_q;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          if (last_idx == '0) begin
            vec_re    = 1'b1;
            vec_raddr = '0;
          end else begin
            time_re    = 1'b1;
            time_raddr = AW'(1);
          end
        end
      end
      ST_SRCH: begin
        if (t_lt) begin
          time_re    = 1'b1;
          time_raddr = rd_idx_q - AW'(1);
          vec_re     = 1'b1;
          vec_raddr  = rd_idx_q - AW'(1);
        end else if (rd_idx_q == last_idx) begin
          vec_re    = 1'b1;
          vec_raddr = rd_idx_q;
        end else begin
          time_re    = 1'b1;
          time_raddr = rd_idx_q + AW'(1);
        end
      end
      ST_LO: begin
        if (!t_lt) begin
          vec_re    = 1'b1;
          vec_raddr = rd_idx_q;
          div_start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      time_mem[AW'(key_index_i)] <= key_time_i;
    end
    if (time_re) begin
      time_rdata_q <= time_mem[time_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      vec_mem[AW'(key_index_i)] <= {key_z_i, key_y_i, key_x_i};
    end
    if (vec_re) begin
      vec_rdata_q <= vec_mem[vec_raddr];
    end
  end

  kfvi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (t_q - time_rdata_q),
    .den_i  (t_hi_q - time_rdata_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    csel   = (mc_q < 3'd3) ? mc_q[1:0] : 2'd0;
    rsel   = mc_q[1:0] - 2'd2;
    diff_d = $signed({b_q[csel][VAL_W-1], b_q[csel]}) -
             $signed({a_q[csel][VAL_W-1], a_q[csel]});
    prod_d = diff_q * $signed({1'b0, f_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      key_count_q   <= CNT_W'(1);
      rd_idx_q      <= '0;
      mc_q          <= '0;
      out_x_q       <= '0;
      out_y_q       <= '0;
      out_z_q       <= '0;
      out_clamped_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_count_q <= cfg_data_i;
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (query_fire) begin
            if (last_idx == '0) begin
              state_q <= ST_KEY;
            end else begin
              rd_idx_q <= AW'(1);
              state_q  <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (t_lt) begin
            state_q <= ST_LO;
          end else if (rd_idx_q == last_idx) begin
            state_q <= ST_KEY;
          end else begin
            rd_idx_q <= rd_idx_q + AW'(1);
          end
        end
        ST_LO: begin
          state_q <= t_lt ? ST_WB : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            mc_q    <= '0;
            state_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          mc_q <= mc_q + 3'd1;
          if (mc_q == MixLast) begin
            state_q <= ST_WB;
          end
        end
        ST_KEY: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (wb_fire) begin
            out_x_q       <= res_q[0];
            out_y_q       <= res_q[1];
            out_z_q       <= res_q[2];
            out_clamped_q <= clamp_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          t_q     <= sample_time_i;
          clamp_q <= 1'b0;
        end
      end
      ST_SRCH: begin
        if (t_lt) begin
          t_hi_q <= time_rdata_q;
        end else if (rd_idx_q == last_idx) begin
          clamp_q <= t_q > time_rdata_q;
        end
      end
      ST_LO: begin
        a_q <= vec_rdata_q;
        if (t_lt) begin
          res_q   <= vec_rdata_q;
          clamp_q <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          f_q <= div_quot;
          b_q <= vec_rdata_q;
        end
      end
      ST_MIX: begin
        if (mc_q <= 3'd2) begin
          diff_q <= diff_d;
        end
        if (mc_q >= 3'd1 && mc_q <= 3'd3) begin
          prod_q <= prod_d;
        end
        if (mc_q >= 3'd2) begin
          res_q[rsel] <= a_q[rsel] + prod_q[VAL_W+FRAC_W-1:FRAC_W];
        end
      end
      ST_KEY: begin
        res_q <= vec_rdata_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = $signed(out_x_q);
  assign out_y_o     = $signed(out_y_q);
  assign out_z_o     = $signed(out_z_q);
  assign clamped_o   = out_clamped_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH |-> (rd_idx_q != '0) && (rd_idx_q <= last_idx))
    else $error("key search index left the keys in use");

  a_wb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) && out_valid_o && !out_ready_i |=> state_q == ST_WB)
    else $error("finished result dropped while the output word was stalled");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire && (last_idx != '0) |=> !in_ready_o ##1 !in_ready_o)
    else $error("new word accepted while a query was still being searched");

endmodule

`default_nettype wire
